@@ rtl/nzsm_pkg.sv @@
// Package for the nearest zone sample map: result status codes and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nzsm_pkg;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_TABLE_FULL = 2'd1;
    localparam logic [1:0] STATUS_ZONE_FULL  = 2'd2;
    localparam logic [1:0] STATUS_NO_MATCH   = 2'd3;

    // force value that stands for minus infinity in a lookup
    localparam logic signed [13:0] FORCE_NEG_INF = 14'sh2000;

    localparam int PITCH_W  = 19;
    localparam int FORCE_W  = 14;
    localparam int SAMPLE_W = 9;
    localparam int VOLUME_W = 16;
    localparam int RAND_W   = 16;
    localparam int IN_W     = 96;
    localparam int OUT_W    = 72;

    typedef struct packed {
        logic       capture;    // latch input transfer and start zone scan
        logic       add_write;  // write zone record and slot entry
        logic       calc_idx;   // register the random entry index
        logic       slot_read;  // read the chosen slot entry
        logic       load_out;   // load output register
        logic [1:0] out_status;
    } t_cmd;

    typedef struct packed {
        logic kind;         // captured kind: 1 lookup
        logic scan_done;
        logic hit;          // add: key found
        logic hit_full;     // add: found zone holds all its entries
        logic table_full;
        logic empty;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

@@ rtl/nzsm_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module nzsm_ram #(
    parameter int W = 8,
    parameter int D = 64,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [W-1:0]  i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [W-1:0]  o_rd_data
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

@@ rtl/nzsm_ctrl.sv @@
// Controller state machine for the nearest zone sample map.
// Depends on nzsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nzsm_ctrl
    import nzsm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire t_stat i_stat,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_IDX    = 3'd3;
    localparam logic [2:0] S_SREAD  = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0] r_state, n_state;
    logic [1:0] r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= STATUS_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.out_status = r_status;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_OUT;
                if (!i_stat.kind) begin
                    if (i_stat.hit && i_stat.hit_full) begin
                        n_status = STATUS_ZONE_FULL;
                    end else if (!i_stat.hit && i_stat.table_full) begin
                        n_status = STATUS_TABLE_FULL;
                    end else begin
                        o_cmd.add_write = 1'b1;
                        n_status = STATUS_OK;
                    end
                end else if (i_stat.empty) begin
                    n_status = STATUS_NO_MATCH;
                end else begin
                    o_cmd.calc_idx = 1'b1;
                    n_status = STATUS_OK;
                    n_state = S_IDX;
                end
            end
            S_IDX: begin
                o_cmd.slot_read = 1'b1;
                n_state = S_SREAD;
            end
            S_SREAD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/nzsm_datapath.sv @@
// Datapath: zone and slot RAMs, zone scan pipeline with distance unit,
// entry pick and output register. Depends on nzsm_pkg and nzsm_ram.
`timescale 1ns / 1ps
`default_nettype none
module nzsm_datapath
    import nzsm_pkg::*;
#(
    parameter int MAX_ZONES      = 64,
    parameter int SLOTS_PER_ZONE = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    input  wire logic             i_kind,
    input  wire logic [IN_W-1:0]  i_data,
    input  wire logic             i_out_ready,
    output t_stat                 o_stat,
    output logic                  o_out_valid,
    output logic      [OUT_W-1:0] o_out_data
);

    localparam int ZW  = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int CW  = $clog2(MAX_ZONES + 1);
    localparam int FW  = $clog2(SLOTS_PER_ZONE + 1);
    localparam int IW  = (SLOTS_PER_ZONE > 1) ? $clog2(SLOTS_PER_ZONE) : 1;
    localparam int NS  = MAX_ZONES * SLOTS_PER_ZONE;
    localparam int SW  = (NS > 1) ? $clog2(NS) : 1;
    localparam int ZRW = PITCH_W + FORCE_W + FW;
    localparam int SRW = SAMPLE_W + PITCH_W + VOLUME_W;

    // captured item
    logic                       r_kind;
    logic signed [PITCH_W-1:0]  r_qp;
    logic signed [FORCE_W-1:0]  r_qf;
    logic [SAMPLE_W-1:0]        r_sample;
    logic [PITCH_W-1:0]         r_tune;
    logic [VOLUME_W-1:0]        r_vol;
    logic [RAND_W-1:0]          r_rnd;

    logic [CW-1:0] r_count;

    // scan pipeline
    logic          r_busy, r_v1, r_v2;
    logic [CW-1:0] r_addr;
    logic [ZW-1:0] r_i1, r_i2;
    logic [39:0]   r_sqp;
    logic [29:0]   r_sqf;
    logic signed [PITCH_W-1:0] r_p2;
    logic signed [FORCE_W-1:0] r_f2;
    logic [FW-1:0] r_fill2;
    logic          r_low2;

    // add hit
    logic          r_hit;
    logic [ZW-1:0] r_hit_idx;
    logic [FW-1:0] r_hit_fill;

    // best zone
    logic          r_have;
    logic [ZW-1:0] r_best_idx;
    logic [51:0]   r_best_d;
    logic signed [PITCH_W-1:0] r_best_p;
    logic signed [FORCE_W-1:0] r_best_f;
    logic [FW-1:0] r_best_fill;
    logic          r_best_low;

    logic [IW-1:0]    r_idx;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    // RAM ports
    logic           zr_rd_en, zr_wr_en;
    logic [ZW-1:0]  zr_wr_addr;
    logic [ZRW-1:0] zr_wr_data, zr_rd_data;
    logic [SW-1:0]  sr_wr_addr, sr_rd_addr;
    logic [SRW-1:0] sr_wr_data, sr_rd_data;

    nzsm_ram #(.W(ZRW), .D(MAX_ZONES)) u_zone_ram (
        .i_clk     (i_clk),
        .i_wr_en   (zr_wr_en),
        .i_wr_addr (zr_wr_addr),
        .i_wr_data (zr_wr_data),
        .i_rd_en   (zr_rd_en),
        .i_rd_addr (r_addr[ZW-1:0]),
        .o_rd_data (zr_rd_data)
    );

    nzsm_ram #(.W(SRW), .D(NS)) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.add_write),
        .i_wr_addr (sr_wr_addr),
        .i_wr_data (sr_wr_data),
        .i_rd_en   (i_cmd.slot_read),
        .i_rd_addr (sr_rd_addr),
        .o_rd_data (sr_rd_data)
    );

    // stage 1: zone record out of RAM
    logic signed [PITCH_W-1:0] p1;
    logic signed [FORCE_W-1:0] f1;
    logic [FW-1:0]             fill1;
    logic signed [PITCH_W:0]   dp;
    logic signed [FORCE_W:0]   df;
    logic signed [39:0]        sqp_c;
    logic signed [29:0]        sqf_c;
    logic                      low1;

    assign p1    = zr_rd_data[PITCH_W-1:0];
    assign f1    = zr_rd_data[PITCH_W +: FORCE_W];
    assign fill1 = zr_rd_data[PITCH_W+FORCE_W +: FW];
    assign dp    = {p1[PITCH_W-1], p1} - {r_qp[PITCH_W-1], r_qp};
    assign df    = {f1[FORCE_W-1], f1} - {r_qf[FORCE_W-1], r_qf};
    assign sqp_c = 40'(dp) * 40'(dp);
    assign sqf_c = 30'(df) * 30'(df);
    assign low1  = (p1 < r_qp) || ((p1 == r_qp) && (f1 <= r_qf));

    // stage 2: distance and tie rule against the best so far
    logic [51:0] cand_d;
    logic        key_gt, key_lt, tie_win, better;

    assign cand_d = (r_qf == FORCE_NEG_INF) ? 52'd0
                  : ({r_sqp, 12'd0} + {22'd0, r_sqf});
    assign key_gt = (r_p2 > r_best_p) || ((r_p2 == r_best_p) && (r_f2 > r_best_f));
    assign key_lt = (r_p2 < r_best_p) || ((r_p2 == r_best_p) && (r_f2 < r_best_f));
    assign tie_win = (r_low2 != r_best_low) ? r_low2 : (r_low2 ? key_gt : key_lt);
    assign better = !r_have || (cand_d < r_best_d) || ((cand_d == r_best_d) && tie_win);

    logic scan_issue, scan_done;
    assign scan_issue = r_busy && (r_addr < r_count);
    assign scan_done  = r_busy && (r_addr == r_count) && !r_v1 && !r_v2;
    assign zr_rd_en   = scan_issue;

    // add writes: zone record with new fill, slot entry at old fill
    logic [ZW-1:0] wr_zone;
    logic [FW-1:0] wr_fill;
    assign wr_zone    = r_hit ? r_hit_idx : r_count[ZW-1:0];
    assign wr_fill    = r_hit ? r_hit_fill : FW'(0);
    assign zr_wr_en   = i_cmd.add_write;
    assign zr_wr_addr = wr_zone;
    assign zr_wr_data = {FW'(wr_fill + FW'(1)), r_qf, r_qp};
    assign sr_wr_addr = SW'(SW'(wr_zone) * SW'(SLOTS_PER_ZONE) + SW'(wr_fill));
    assign sr_wr_data = {r_vol, r_tune, r_sample};
    assign sr_rd_addr = SW'(SW'(r_best_idx) * SW'(SLOTS_PER_ZONE) + SW'(r_idx));

    logic [RAND_W+FW-1:0] pick;
    assign pick = (RAND_W+FW)'(r_rnd) * (RAND_W+FW)'(r_best_fill);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= scan_issue;
            r_v2 <= r_v1;
            if (i_cmd.capture) begin
                r_busy <= 1'b1;
            end else if (scan_done) begin
                r_busy <= 1'b0;
            end
            if (i_cmd.add_write && !r_hit) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_kind;
            r_qp     <= i_data[18:0];
            r_qf     <= i_data[32:19];
            r_sample <= i_data[41:33];
            r_tune   <= i_data[60:42];
            r_vol    <= i_data[76:61];
            r_rnd    <= i_data[92:77];
            r_addr   <= '0;
            r_hit    <= 1'b0;
            r_have   <= 1'b0;
        end else if (scan_issue) begin
            r_addr <= r_addr + CW'(1);
        end
        if (scan_issue) begin
            r_i1 <= r_addr[ZW-1:0];
        end
        if (r_v1) begin
            r_i2    <= r_i1;
            r_sqp   <= sqp_c;
            r_sqf   <= sqf_c;
            r_p2    <= p1;
            r_f2    <= f1;
            r_fill2 <= fill1;
            r_low2  <= low1;
            if (!r_kind && (p1 == r_qp) && (f1 == r_qf)) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_i1;
                r_hit_fill <= fill1;
            end
        end
        if (r_v2 && r_kind && better) begin
            r_have      <= 1'b1;
            r_best_idx  <= r_i2;
            r_best_d    <= cand_d;
            r_best_p    <= r_p2;
            r_best_f    <= r_f2;
            r_best_fill <= r_fill2;
            r_best_low  <= r_low2;
        end
        if (i_cmd.calc_idx) begin
            r_idx <= pick[RAND_W +: IW];
        end
        if (i_cmd.load_out) begin
            if (r_kind && (i_cmd.out_status == STATUS_OK)) begin
                r_out_data <= {7'd0, r_best_p, sr_rd_data, i_cmd.out_status};
            end else begin
                r_out_data <= {(OUT_W-2)'(0), i_cmd.out_status};
            end
        end
    end

    assign o_stat.kind       = r_kind;
    assign o_stat.scan_done  = scan_done;
    assign o_stat.hit        = r_hit;
    assign o_stat.hit_full   = (r_hit_fill >= FW'(SLOTS_PER_ZONE));
    assign o_stat.table_full = (r_count == CW'(MAX_ZONES));
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

endmodule
`default_nettype wire

@@ rtl/nearest_zone_sample_map.sv @@
// Nearest zone sample map, top level; depends on nzsm_pkg, nzsm_ctrl, nzsm_datapath, nzsm_ram.
// The scan reads one zone record per cycle before the result of an add or a lookup is
// loaded into the output register.
// One item at a time: input ready again in the cycle after the result is loaded, so no
// new item is taken while the scan runs or while the output waits for a free register.
// Synchronous active-low reset empties the zone table (zone_count = 0).
`timescale 1ns / 1ps
`default_nettype none
module nearest_zone_sample_map
    import nzsm_pkg::*;
#(
    parameter int MAX_ZONES      = 64,
    parameter int SLOTS_PER_ZONE = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    // pitch_cents, force_level, sample_number, entry_tuning, entry_volume,
    // random_value from bit 0 up
    input  wire logic [IN_W-1:0]  i_s_tdata,
    // kind
    input  wire logic             i_s_tuser,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    // status, found_sample, found_tuning, found_volume, zone_pitch from bit 0 up
    output logic      [OUT_W-1:0] o_m_tdata
);

    t_cmd  cmd;
    t_stat stat;

    nzsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_stat     (stat),
        .o_in_ready (o_s_tready),
        .o_cmd      (cmd)
    );

    nzsm_datapath #(
        .MAX_ZONES      (MAX_ZONES),
        .SLOTS_PER_ZONE (SLOTS_PER_ZONE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_kind      (i_s_tuser),
        .i_data      (i_s_tdata),
        .i_out_ready (i_m_tready),
        .o_stat      (stat),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (o_m_tdata)
    );

endmodule
`default_nettype wire
